@@ design/adenv_pkg.sv @@
package adenv_pkg;

  localparam int DEF_LEVEL_FRAC_BITS = 16;

  localparam int STEP_W    = 16;
  localparam int OUT_W     = 17;
  localparam int STAGE_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int S_DATA_W  = 8;
  localparam int M_DATA_W  = 40;

  localparam logic [STAGE_W-1:0] STG_IDLE   = 2'd0;
  localparam logic [STAGE_W-1:0] STG_ATTACK = 2'd1;
  localparam logic [STAGE_W-1:0] STG_DECAY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_MODE   = 2'd2;

  localparam logic [STEP_W-1:0] ATTACK_STEP_RST = 16'd655;
  localparam logic [STEP_W-1:0] DECAY_STEP_RST  = 16'd65;

  localparam logic [OUT_W-1:0] OUT_ONE = 17'd65536;

  typedef struct packed {
    logic [STEP_W-1:0] attack_step;
    logic [STEP_W-1:0] decay_step;
    logic              loop_mode;
  } cfg_t;

endpackage

@@ design/adenv_step.sv @@
module adenv_step #(
  parameter int LEVEL_FRAC_BITS = adenv_pkg::DEF_LEVEL_FRAC_BITS
) (
  input  adenv_pkg::cfg_t                 cfg,
  input  logic                            gate,
  input  logic                            last_gate,
  input  logic [adenv_pkg::STAGE_W-1:0]   stage,
  input  logic [LEVEL_FRAC_BITS:0]        level,
  output logic [adenv_pkg::STAGE_W-1:0]   stage_next,
  output logic [LEVEL_FRAC_BITS:0]        level_next,
  output logic [adenv_pkg::OUT_W-1:0]     env_level,
  output logic [adenv_pkg::OUT_W-1:0]     inverted_level
);
  import adenv_pkg::*;

  localparam int L = LEVEL_FRAC_BITS + 1;
  localparam int P = STEP_W + L;
  localparam logic [L-1:0] ONE    = L'(64'd1 << LEVEL_FRAC_BITS);
  localparam logic [L-1:0] TARGET = L'((64'd102 * (64'd1 << LEVEL_FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [L-1:0] FLOOR  = L'(((64'd1 << LEVEL_FRAC_BITS) + 64'd5000) / 64'd10000);

  logic [STAGE_W-1:0] eff_stage;
  logic [STEP_W-1:0]  mul_step;
  logic [L-1:0]       mul_opnd;
  logic [P-1:0]       prod;
  logic [P-1:0]       rounded;
  logic [L-1:0]       amt;
  logic [L:0]         att_sum;
  logic [L-1:0]       dec_val;
  logic [L+STEP_W-1:0] lvl_wide;

  assign eff_stage = (gate && !last_gate) ? STG_ATTACK : stage;

  // one shared multiplier: attack scales the distance to target, decay the level
  assign mul_step = (eff_stage == STG_ATTACK) ? cfg.attack_step : cfg.decay_step;
  assign mul_opnd = (eff_stage == STG_ATTACK) ? (TARGET - level) : level;
  assign prod     = P'(mul_step) * P'(mul_opnd);
  assign rounded  = prod + P'({STEP_W{1'b1}});
  assign amt      = rounded[P-1:STEP_W];

  assign att_sum = {1'b0, level} + {1'b0, amt};
  assign dec_val = (amt >= level) ? '0 : (level - amt);

  always_comb begin
    stage_next = STG_IDLE;
    level_next = '0;
    case (eff_stage)
      STG_ATTACK: begin
        if (att_sum >= {1'b0, ONE}) begin
          level_next = ONE;
          stage_next = STG_DECAY;
        end else begin
          level_next = att_sum[L-1:0];
          stage_next = STG_ATTACK;
        end
      end
      STG_DECAY: begin
        if (dec_val < FLOOR) begin
          level_next = '0;
          stage_next = cfg.loop_mode ? STG_ATTACK : STG_IDLE;
        end else begin
          level_next = dec_val;
          stage_next = STG_DECAY;
        end
      end
      default: begin
        level_next = '0;
        stage_next = STG_IDLE;
      end
    endcase
  end

  // rescale to 16 fraction bits: (level_next << 16) >> F
  assign lvl_wide       = {level_next, {STEP_W{1'b0}}};
  assign env_level      = lvl_wide[LEVEL_FRAC_BITS+16:LEVEL_FRAC_BITS];
  assign inverted_level = OUT_ONE - env_level;

endmodule

@@ design/ad_envelope_generator_top.sv @@
// Attack-decay envelope generator. Each transfer on the s_ side carries one
// gate sample; each sample gives exactly one m_ transfer with the envelope
// level (Q1.16), its complement to 1.0 and the stage after that sample.
// Throughput is one sample per clock while m_tready stays high. A taken
// sample sits in the input register; when the output can advance, its result
// is loaded into the stage, level and output data registers and offered on m_.
// The cycle is set by one 16 x (LEVEL_FRAC_BITS+1) multiply, a round-up add,
// the level add and a compare feeding the level register. The user writes
// step fractions and loop mode on the cfg port while the block is idle;
// the block itself does not enforce it.
module ad_envelope_generator_top #(
  parameter int LEVEL_FRAC_BITS = adenv_pkg::DEF_LEVEL_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [adenv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [adenv_pkg::CFG_W-1:0]       cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [adenv_pkg::S_DATA_W-1:0]    s_tdata,  // [0] gate
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [adenv_pkg::M_DATA_W-1:0]    m_tdata   // [16:0] env_level,
                                                      // [33:17] inverted_level,
                                                      // [35:34] stage
);
  import adenv_pkg::*;

  localparam int L = LEVEL_FRAC_BITS + 1;

  cfg_t               cfg;
  logic               in_valid;
  logic               in_gate;
  logic               last_gate;
  logic [STAGE_W-1:0] stage;
  logic [L-1:0]       level;
  logic [STAGE_W-1:0] stage_next;
  logic [L-1:0]       level_next;
  logic [OUT_W-1:0]   env_level;
  logic [OUT_W-1:0]   inverted_level;
  logic               adv;
  logic               fire;

  assign adv      = !m_tvalid || m_tready;
  assign fire     = in_valid && adv;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.attack_step <= ATTACK_STEP_RST;
      cfg.decay_step  <= DECAY_STEP_RST;
      cfg.loop_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATTACK_STEP: cfg.attack_step <= cfg_data;
        REG_DECAY_STEP:  cfg.decay_step  <= cfg_data;
        REG_LOOP_MODE:   cfg.loop_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (adv) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_gate <= s_tdata[0];
    end
  end

  adenv_step #(
    .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
  ) u_step (
    .cfg            (cfg),
    .gate           (in_gate),
    .last_gate      (last_gate),
    .stage          (stage),
    .level          (level),
    .stage_next     (stage_next),
    .level_next     (level_next),
    .env_level      (env_level),
    .inverted_level (inverted_level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= STG_IDLE;
      level     <= '0;
      last_gate <= 1'b0;
      m_tvalid  <= 1'b0;
    end else if (fire) begin
      stage     <= stage_next;
      level     <= level_next;
      last_gate <= in_gate;
      m_tvalid  <= 1'b1;
    end else if (m_tready) begin
      m_tvalid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {4'b0, stage_next, inverted_level, env_level};
    end
  end

  localparam logic [L-1:0] LVL_ONE = L'(64'd1 << LEVEL_FRAC_BITS);

  a_level_max: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_ONE)
    else $error("level above 1.0");

  a_stage_code: assert property (@(posedge clk) disable iff (rst)
    stage == STG_IDLE || stage == STG_ATTACK || stage == STG_DECAY)
    else $error("unused stage code");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[35:34] == STG_IDLE) |-> (m_tdata[16:0] == '0))
    else $error("idle with nonzero level");

  a_complement: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[16:0] + m_tdata[33:17] == OUT_ONE))
    else $error("inverted level mismatch");

  a_gate_track: assert property (@(posedge clk) disable iff (rst)
    fire |=> (last_gate == $past(in_gate)))
    else $error("gate history not updated");

endmodule
